FILE: rtl/ybcg_pkg.sv
// ----------------------------------------------------------------------------
// ybcg_pkg: shared types and constants for the yaw box cell gate
// Holds widths, register indexes, stage payload structures and helpers.
// ----------------------------------------------------------------------------
package ybcg_pkg;

  localparam int FWD_FRAC = 15;
  localparam int HW       = 31;
  localparam int DW       = 35;
  localparam int EW       = 33;
  localparam int WW       = 54;
  localparam int AW       = 5;

  localparam logic [2:0] REG_OUTER_X = 3'd0;
  localparam logic [2:0] REG_OUTER_Y = 3'd1;
  localparam logic [2:0] REG_OUTER_Z = 3'd2;
  localparam logic [2:0] REG_INNER_X = 3'd3;
  localparam logic [2:0] REG_INNER_Y = 3'd4;
  localparam logic [2:0] REG_INNER_Z = 3'd5;
  localparam logic [2:0] REG_INVERT  = 3'd6;
  localparam logic [2:0] REG_FLAT    = 3'd7;

  typedef logic signed [WW-1:0] wide_t;

  typedef struct packed {
    logic [HW-1:0] outer_x;
    logic [HW-1:0] outer_y;
    logic [HW-1:0] outer_z;
    logic [HW-1:0] inner_x;
    logic [HW-1:0] inner_y;
    logic [HW-1:0] inner_z;
    logic          invert;
    logic          flat;
  } cfg_t;

  typedef struct packed {
    logic pos_ok;
    logic yaw;
    logic al_xy;
    logic al_int;
    logic z_touch;
    logic z_int;
  } flags_t;

  typedef struct packed {
    flags_t                fl;
    logic signed [15:0]    fx;
    logic signed [15:0]    fy;
    logic signed [16:0]    afx;
    logic signed [16:0]    afy;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic signed [EW-1:0]  ex;
    logic signed [EW-1:0]  ey;
    logic signed [EW-1:0]  cx0;
    logic signed [EW-1:0]  cx1;
    logic signed [EW-1:0]  cy0;
    logic signed [EW-1:0]  cy1;
  } s1_t;

  typedef struct packed {
    flags_t fl;
    wide_t  wx_l;
    wide_t  wy_l;
    wide_t  ex_s;
    wide_t  ey_s;
    wide_t  ax_hx;
    wide_t  ay_hy;
    wide_t  ay_hx;
    wide_t  ax_hy;
    wide_t  f_dx;
    wide_t  f_dy;
    wide_t  r_dy;
    wide_t  r_dx;
    wide_t  a_ex;
    wide_t  b_ey;
    wide_t  b_ex;
    wide_t  a_ey;
    wide_t  xf0;
    wide_t  xf1;
    wide_t  yf0;
    wide_t  yf1;
    wide_t  yfx0;
    wide_t  yfx1;
    wide_t  xfy0;
    wide_t  xfy1;
  } s2_t;

  typedef struct packed {
    flags_t fl;
    wide_t  wx_l;
    wide_t  wx_r;
    wide_t  wy_l;
    wide_t  wy_r;
    wide_t  fw_l;
    wide_t  fw_r;
    wide_t  rt_l;
    wide_t  rt_r;
    wide_t  cf0;
    wide_t  cf1;
    wide_t  cf2;
    wide_t  cf3;
    wide_t  cr0;
    wide_t  cr1;
    wide_t  cr2;
    wide_t  cr3;
  } s3_t;

  // True when the magnitude of v exceeds r.
  function automatic logic mag_gt(input wide_t v, input wide_t r);
    return (v > r) || ((-v) > r);
  endfunction

endpackage

FILE: rtl/ybcg_in_if.sv
// ----------------------------------------------------------------------------
// ybcg_in_if: request channel into the gate
// Valid/ready channel carrying the source position, yaw and cell bounds.
// ----------------------------------------------------------------------------
interface ybcg_in_if;
  logic               valid;
  logic               ready;
  logic               position_valid;
  logic signed [31:0] source_x;
  logic signed [31:0] source_y;
  logic signed [31:0] source_z;
  logic signed [15:0] forward_x;
  logic signed [15:0] forward_y;
  logic signed [31:0] cell_min_x;
  logic signed [31:0] cell_min_y;
  logic signed [31:0] cell_min_z;
  logic signed [31:0] cell_max_x;
  logic signed [31:0] cell_max_y;
  logic signed [31:0] cell_max_z;

  modport source (
    output valid, position_valid, source_x, source_y, source_z, forward_x, forward_y,
           cell_min_x, cell_min_y, cell_min_z, cell_max_x, cell_max_y, cell_max_z,
    input  ready
  );
  modport sink (
    input  valid, position_valid, source_x, source_y, source_z, forward_x, forward_y,
           cell_min_x, cell_min_y, cell_min_z, cell_max_x, cell_max_y, cell_max_z,
    output ready
  );
endinterface

FILE: rtl/ybcg_out_if.sv
// ----------------------------------------------------------------------------
// ybcg_out_if: result channel out of the gate
// Valid/ready channel carrying the gate decision and its two components.
// ----------------------------------------------------------------------------
interface ybcg_out_if;
  logic valid;
  logic ready;
  logic gate_pass;
  logic outer_touch;
  logic in_interior;

  modport source (output valid, gate_pass, outer_touch, in_interior, input ready);
  modport sink (input valid, gate_pass, outer_touch, in_interior, output ready);
endinterface

FILE: rtl/yaw_box_cell_gate_top.sv
// ----------------------------------------------------------------------------
// yaw_box_cell_gate_top: box shell versus grid cell overlap gate
// Four-stage pipeline deciding whether a yawed or aligned box touches a cell.
// ----------------------------------------------------------------------------
// Usage:
// Each request on in_if carries a source position, an optional yaw direction
// (both components zero selects the axis-aligned test) and one cell's bounds.
// Every request yields exactly one result on out_if: gate_pass, outer_touch
// and in_interior. Box extents and the invert and flat mode bits are written
// through the APB port before traffic starts and must not change while
// requests are in flight.
// Each accepted request passes through four registers on its way to out_if. The
// accepting edge loads the first of four registers: offsets and interval
// tests, products, sums, then compares into the output register. One request
// is accepted every cycle while out_if.ready is high: every stage then moves on.
// Each stage carries its own valid bit and moves forward whenever the stage
// after it is empty or moving, so bubbles close up. When the receiver holds
// out_if.ready low the result stays put and the stages fill behind it; in_if
// drops ready only once all four are occupied. Synchronous reset clears all
// valid bits and the configuration registers; no results are pending after.
// ----------------------------------------------------------------------------
module yaw_box_cell_gate_top (
  input  logic                    clk,
  input  logic                    rst_n,
  ybcg_in_if.sink                 in_if,
  ybcg_out_if.source              out_if,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ybcg_pkg::AW-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  ybcg_pkg::cfg_t cfg;
  logic           v1, v2, v3;
  logic           r1, r2, r3;
  ybcg_pkg::s1_t  d1;
  ybcg_pkg::s2_t  d2;
  ybcg_pkg::s3_t  d3;

  // Register file for extents and mode bits.
  ybcg_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // Stage one: center offsets, extents and the aligned interval checks.
  ybcg_prep u_prep (
    .clk, .rst_n, .cfg, .in_if, .v_o(v1), .d_o(d1), .rdy_i(r1)
  );

  // Stage two: all projection products.
  ybcg_mult u_mult (
    .clk, .rst_n, .cfg, .v_i(v1), .d_i(d1), .rdy_o(r1), .v_o(v2), .d_o(d2), .rdy_i(r2)
  );

  // Stage three: projected offsets and radii.
  ybcg_sum u_sum (
    .clk, .rst_n, .cfg, .v_i(v2), .d_i(d2), .rdy_o(r2), .v_o(v3), .d_o(d3), .rdy_i(r3)
  );

  // Stage four: compares, hollow exclusion, inversion, output register.
  ybcg_decide u_decide (
    .clk, .rst_n, .cfg, .v_i(v3), .d_i(d3), .rdy_o(r3), .out_if
  );

  // An accepted request always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> v1)
    else $error("accepted request did not enter the first stage");

  // The interior is only examined for cells that touch the outer box.
  a_interior_needs_touch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.in_interior) |-> out_if.outer_touch)
    else $error("interior flagged without outer touch");

  // The decision is the touch with interior removed, then optionally inverted.
  a_pass_formula: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |->
      (out_if.gate_pass == ((out_if.outer_touch && !out_if.in_interior) ^ cfg.invert)))
    else $error("gate_pass inconsistent with touch, interior and invert");

  // With a zero interior width the hollow test is off.
  a_hollow_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && ((cfg.inner_x == '0) || (cfg.inner_y == '0))) |-> !out_if.in_interior)
    else $error("interior flagged while hollow is disabled");

endmodule

FILE: rtl/ybcg_cfg.sv
// ----------------------------------------------------------------------------
// ybcg_cfg: configuration register file
// APB-style write and read of the box extents and mode bits.
// ----------------------------------------------------------------------------
module ybcg_cfg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ybcg_pkg::AW-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output ybcg_pkg::cfg_t         cfg
);

  ybcg_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr) begin
      unique case (idx)
        ybcg_pkg::REG_OUTER_X: cfg_r.outer_x <= pwdata[30:0];
        ybcg_pkg::REG_OUTER_Y: cfg_r.outer_y <= pwdata[30:0];
        ybcg_pkg::REG_OUTER_Z: cfg_r.outer_z <= pwdata[30:0];
        ybcg_pkg::REG_INNER_X: cfg_r.inner_x <= pwdata[30:0];
        ybcg_pkg::REG_INNER_Y: cfg_r.inner_y <= pwdata[30:0];
        ybcg_pkg::REG_INNER_Z: cfg_r.inner_z <= pwdata[30:0];
        ybcg_pkg::REG_INVERT:  cfg_r.invert  <= pwdata[0];
        ybcg_pkg::REG_FLAT:    cfg_r.flat    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ybcg_pkg::REG_OUTER_X: prdata = {1'b0, cfg_r.outer_x};
      ybcg_pkg::REG_OUTER_Y: prdata = {1'b0, cfg_r.outer_y};
      ybcg_pkg::REG_OUTER_Z: prdata = {1'b0, cfg_r.outer_z};
      ybcg_pkg::REG_INNER_X: prdata = {1'b0, cfg_r.inner_x};
      ybcg_pkg::REG_INNER_Y: prdata = {1'b0, cfg_r.inner_y};
      ybcg_pkg::REG_INNER_Z: prdata = {1'b0, cfg_r.inner_z};
      ybcg_pkg::REG_INVERT:  prdata = {31'd0, cfg_r.invert};
      ybcg_pkg::REG_FLAT:    prdata = {31'd0, cfg_r.flat};
      default:               prdata = '0;
    endcase
  end

endmodule

FILE: rtl/ybcg_prep.sv
// ----------------------------------------------------------------------------
// ybcg_prep: first pipeline stage
// Forms centre offsets, extents, corner offsets and the aligned interval tests.
// ----------------------------------------------------------------------------
module ybcg_prep (
  input  logic           clk,
  input  logic           rst_n,
  input  ybcg_pkg::cfg_t cfg,
  ybcg_in_if.sink        in_if,
  output logic           v_o,
  output ybcg_pkg::s1_t  d_o,
  input  logic           rdy_i
);

  logic          v_r;
  ybcg_pkg::s1_t d_r;
  ybcg_pkg::s1_t d_nxt;
  logic          adv;

  logic signed [33:0] sx, sy, sz, mnx, mny, mnz, mxx, mxy, mxz;
  logic signed [33:0] hx, hy, hz, ix, iy, iz;

  assign adv         = !v_r || rdy_i;
  assign in_if.ready = adv;
  assign v_o         = v_r;
  assign d_o         = d_r;

  always_comb begin
    sx  = 34'(in_if.source_x);
    sy  = 34'(in_if.source_y);
    sz  = 34'(in_if.source_z);
    mnx = 34'(in_if.cell_min_x);
    mny = 34'(in_if.cell_min_y);
    mnz = 34'(in_if.cell_min_z);
    mxx = 34'(in_if.cell_max_x);
    mxy = 34'(in_if.cell_max_y);
    mxz = 34'(in_if.cell_max_z);
    hx  = signed'({3'b000, cfg.outer_x});
    hy  = signed'({3'b000, cfg.outer_y});
    hz  = signed'({3'b000, cfg.outer_z});
    ix  = signed'({3'b000, cfg.inner_x});
    iy  = signed'({3'b000, cfg.inner_y});
    iz  = signed'({3'b000, cfg.inner_z});

    d_nxt.fl.pos_ok  = in_if.position_valid;
    d_nxt.fl.yaw     = (in_if.forward_x != '0) || (in_if.forward_y != '0);
    d_nxt.fl.al_xy   = (sx - hx <= mxx) && (mnx <= sx + hx) &&
                       (sy - hy <= mxy) && (mny <= sy + hy);
    d_nxt.fl.al_int  = (mnx >= sx - ix) && (mxx <= sx + ix) &&
                       (mny >= sy - iy) && (mxy <= sy + iy);
    d_nxt.fl.z_touch = (sz - hz <= mxz) && (mnz <= sz + hz);
    d_nxt.fl.z_int   = (mnz >= sz - iz) && (mxz <= sz + iz);

    d_nxt.fx  = in_if.forward_x;
    d_nxt.fy  = in_if.forward_y;
    d_nxt.afx = in_if.forward_x[15] ? -17'(in_if.forward_x) : 17'(in_if.forward_x);
    d_nxt.afy = in_if.forward_y[15] ? -17'(in_if.forward_y) : 17'(in_if.forward_y);
    d_nxt.dx  = 35'(mnx) + 35'(mxx) - (35'(sx) <<< 1);
    d_nxt.dy  = 35'(mny) + 35'(mxy) - (35'(sy) <<< 1);
    d_nxt.ex  = 33'(in_if.cell_max_x) - 33'(in_if.cell_min_x);
    d_nxt.ey  = 33'(in_if.cell_max_y) - 33'(in_if.cell_min_y);
    d_nxt.cx0 = 33'(in_if.cell_min_x) - 33'(in_if.source_x);
    d_nxt.cx1 = 33'(in_if.cell_max_x) - 33'(in_if.source_x);
    d_nxt.cy0 = 33'(in_if.cell_min_y) - 33'(in_if.source_y);
    d_nxt.cy1 = 33'(in_if.cell_max_y) - 33'(in_if.source_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_if.valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

FILE: rtl/ybcg_mult.sv
// ----------------------------------------------------------------------------
// ybcg_mult: second pipeline stage
// Forms every projection product, one multiplier per term.
// ----------------------------------------------------------------------------
module ybcg_mult (
  input  logic           clk,
  input  logic           rst_n,
  input  ybcg_pkg::cfg_t cfg,
  input  logic           v_i,
  input  ybcg_pkg::s1_t  d_i,
  output logic           rdy_o,
  output logic           v_o,
  output ybcg_pkg::s2_t  d_o,
  input  logic           rdy_i
);

  logic          v_r;
  ybcg_pkg::s2_t d_r;
  ybcg_pkg::s2_t d_nxt;
  ybcg_pkg::wide_t fx, fy, ax, ay, hx, hy, dx, dy, ex, ey;

  assign rdy_o = !v_r || rdy_i;
  assign v_o   = v_r;
  assign d_o   = d_r;

  always_comb begin
    fx = ybcg_pkg::wide_t'(d_i.fx);
    fy = ybcg_pkg::wide_t'(d_i.fy);
    ax = ybcg_pkg::wide_t'(d_i.afx);
    ay = ybcg_pkg::wide_t'(d_i.afy);
    hx = ybcg_pkg::wide_t'({1'b0, cfg.outer_x});
    hy = ybcg_pkg::wide_t'({1'b0, cfg.outer_y});
    dx = ybcg_pkg::wide_t'(d_i.dx);
    dy = ybcg_pkg::wide_t'(d_i.dy);
    ex = ybcg_pkg::wide_t'(d_i.ex);
    ey = ybcg_pkg::wide_t'(d_i.ey);

    d_nxt.fl    = d_i.fl;
    d_nxt.wx_l  = (d_i.dx[ybcg_pkg::DW-1] ? -dx : dx) <<< ybcg_pkg::FWD_FRAC;
    d_nxt.wy_l  = (d_i.dy[ybcg_pkg::DW-1] ? -dy : dy) <<< ybcg_pkg::FWD_FRAC;
    d_nxt.ex_s  = ex <<< ybcg_pkg::FWD_FRAC;
    d_nxt.ey_s  = ey <<< ybcg_pkg::FWD_FRAC;
    d_nxt.ax_hx = ax * hx;
    d_nxt.ay_hy = ay * hy;
    d_nxt.ay_hx = ay * hx;
    d_nxt.ax_hy = ax * hy;
    d_nxt.f_dx  = fx * dx;
    d_nxt.f_dy  = fy * dy;
    d_nxt.r_dy  = fx * dy;
    d_nxt.r_dx  = fy * dx;
    d_nxt.a_ex  = ax * ex;
    d_nxt.b_ey  = ay * ey;
    d_nxt.b_ex  = ay * ex;
    d_nxt.a_ey  = ax * ey;
    d_nxt.xf0   = ybcg_pkg::wide_t'(d_i.cx0) * fx;
    d_nxt.xf1   = ybcg_pkg::wide_t'(d_i.cx1) * fx;
    d_nxt.yf0   = ybcg_pkg::wide_t'(d_i.cy0) * fy;
    d_nxt.yf1   = ybcg_pkg::wide_t'(d_i.cy1) * fy;
    d_nxt.yfx0  = ybcg_pkg::wide_t'(d_i.cy0) * fx;
    d_nxt.yfx1  = ybcg_pkg::wide_t'(d_i.cy1) * fx;
    d_nxt.xfy0  = ybcg_pkg::wide_t'(d_i.cx0) * fy;
    d_nxt.xfy1  = ybcg_pkg::wide_t'(d_i.cx1) * fy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_o) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && v_i) begin
      d_r <= d_nxt;
    end
  end

endmodule

FILE: rtl/ybcg_sum.sv
// ----------------------------------------------------------------------------
// ybcg_sum: third pipeline stage
// Adds the products into projected offsets and projected radii per axis.
// ----------------------------------------------------------------------------
module ybcg_sum (
  input  logic           clk,
  input  logic           rst_n,
  input  ybcg_pkg::cfg_t cfg,
  input  logic           v_i,
  input  ybcg_pkg::s2_t  d_i,
  output logic           rdy_o,
  output logic           v_o,
  output ybcg_pkg::s3_t  d_o,
  input  logic           rdy_i
);

  logic          v_r;
  ybcg_pkg::s3_t d_r;
  ybcg_pkg::s3_t d_nxt;
  ybcg_pkg::wide_t hx2, hy2;

  assign rdy_o = !v_r || rdy_i;
  assign v_o   = v_r;
  assign d_o   = d_r;

  always_comb begin
    // The box radius on its own axes is the half extent, doubled and scaled.
    hx2 = ybcg_pkg::wide_t'({1'b0, cfg.outer_x}) <<< (ybcg_pkg::FWD_FRAC + 1);
    hy2 = ybcg_pkg::wide_t'({1'b0, cfg.outer_y}) <<< (ybcg_pkg::FWD_FRAC + 1);

    d_nxt.fl   = d_i.fl;
    d_nxt.wx_l = d_i.wx_l;
    d_nxt.wy_l = d_i.wy_l;
    d_nxt.wx_r = d_i.ex_s + ((d_i.ax_hx + d_i.ay_hy) <<< 1);
    d_nxt.wy_r = d_i.ey_s + ((d_i.ay_hx + d_i.ax_hy) <<< 1);
    d_nxt.fw_l = d_i.f_dx + d_i.f_dy;
    d_nxt.fw_r = d_i.a_ex + d_i.b_ey + hx2;
    d_nxt.rt_l = d_i.r_dy - d_i.r_dx;
    d_nxt.rt_r = d_i.b_ex + d_i.a_ey + hy2;
    d_nxt.cf0  = d_i.xf0 + d_i.yf0;
    d_nxt.cf1  = d_i.xf1 + d_i.yf0;
    d_nxt.cf2  = d_i.xf0 + d_i.yf1;
    d_nxt.cf3  = d_i.xf1 + d_i.yf1;
    d_nxt.cr0  = d_i.yfx0 - d_i.xfy0;
    d_nxt.cr1  = d_i.yfx0 - d_i.xfy1;
    d_nxt.cr2  = d_i.yfx1 - d_i.xfy0;
    d_nxt.cr3  = d_i.yfx1 - d_i.xfy1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_o) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && v_i) begin
      d_r <= d_nxt;
    end
  end

endmodule

FILE: rtl/ybcg_decide.sv
// ----------------------------------------------------------------------------
// ybcg_decide: last pipeline stage and output register
// Compares projections, combines the axis tests and drives the result channel.
// ----------------------------------------------------------------------------
module ybcg_decide (
  input  logic           clk,
  input  logic           rst_n,
  input  ybcg_pkg::cfg_t cfg,
  input  logic           v_i,
  input  ybcg_pkg::s3_t  d_i,
  output logic           rdy_o,
  ybcg_out_if.source     out_if
);

  logic v_r, pass_r, touch_r, inter_r;
  logic pass_nxt, touch_nxt, inter_nxt;
  logic yaw_touch, yaw_full, touch_xy, full_xy, hollow_en;
  ybcg_pkg::wide_t ithx, ithy;

  assign rdy_o              = !v_r || out_if.ready;
  assign out_if.valid       = v_r;
  assign out_if.gate_pass   = pass_r;
  assign out_if.outer_touch = touch_r;
  assign out_if.in_interior = inter_r;

  always_comb begin
    ithx = ybcg_pkg::wide_t'({1'b0, cfg.inner_x}) <<< ybcg_pkg::FWD_FRAC;
    ithy = ybcg_pkg::wide_t'({1'b0, cfg.inner_y}) <<< ybcg_pkg::FWD_FRAC;

    yaw_touch = !(d_i.wx_l > d_i.wx_r) && !(d_i.wy_l > d_i.wy_r) &&
                !ybcg_pkg::mag_gt(d_i.fw_l, d_i.fw_r) &&
                !ybcg_pkg::mag_gt(d_i.rt_l, d_i.rt_r);
    yaw_full  = !ybcg_pkg::mag_gt(d_i.cf0, ithx) && !ybcg_pkg::mag_gt(d_i.cr0, ithy) &&
                !ybcg_pkg::mag_gt(d_i.cf1, ithx) && !ybcg_pkg::mag_gt(d_i.cr1, ithy) &&
                !ybcg_pkg::mag_gt(d_i.cf2, ithx) && !ybcg_pkg::mag_gt(d_i.cr2, ithy) &&
                !ybcg_pkg::mag_gt(d_i.cf3, ithx) && !ybcg_pkg::mag_gt(d_i.cr3, ithy);

    touch_xy  = d_i.fl.yaw ? yaw_touch : d_i.fl.al_xy;
    full_xy   = d_i.fl.yaw ? yaw_full : d_i.fl.al_int;
    hollow_en = (cfg.inner_x != '0) && (cfg.inner_y != '0) &&
                (cfg.flat || (cfg.inner_z != '0));

    touch_nxt = d_i.fl.pos_ok && touch_xy && (cfg.flat || d_i.fl.z_touch);
    inter_nxt = touch_nxt && hollow_en && full_xy && (cfg.flat || d_i.fl.z_int);
    pass_nxt  = (touch_nxt && !inter_nxt) ^ cfg.invert;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_o) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && v_i) begin
      pass_r  <= pass_nxt;
      touch_r <= touch_nxt;
      inter_r <= inter_nxt;
    end
  end

endmodule
